>>> rtl/count_min_sketch_engine_assert.svh
// Assertion macros for the count-min sketch engine.
// They expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef COUNT_MIN_SKETCH_ENGINE_ASSERT_SVH
`define COUNT_MIN_SKETCH_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMSE_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("count-min sketch check failed");

// The consequent must hold in the cycle after the antecedent.
`define CMSE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("count-min sketch check failed");

`endif

>>> rtl/cmse_pkg.sv
`default_nettype none

package cmse_pkg;

    localparam int DEF_MAX_ROWS       = 8;
    localparam int DEF_MAX_WIDTH_LOG2 = 10;

    localparam int CNT_W  = 32;
    localparam int HASH_W = 128;
    localparam int CFG_W  = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX        = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] SPECIAL_ESTIMATE = 32'h7FFF_FFFF;

    localparam logic [CFG_W-1:0] RST_WIDTH_LOG2 = 4'd10;
    localparam logic [CFG_W-1:0] RST_ROWS       = 4'd4;

    localparam logic REG_WIDTH_LOG2 = 1'b0;
    localparam logic REG_ROWS       = 1'b1;

    localparam logic CMD_INC   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] minimum;
    } upd_result_t;

endpackage

`default_nettype wire

>>> rtl/cmse_counter_mem.sv
`default_nettype none

module cmse_counter_mem
    import cmse_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_ROWS << DEF_MAX_WIDTH_LOG2,
    parameter int ADDR_W = $clog2(DEF_MAX_ROWS << DEF_MAX_WIDTH_LOG2)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [CNT_W-1:0]  wdata,
    output logic      [CNT_W-1:0]  rdata
);

    logic [CNT_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/cmse_update_unit.sv
`default_nettype none

module cmse_update_unit
    import cmse_pkg::*;
(
    input  wire logic             inc,
    input  wire logic [CNT_W-1:0] count_in,
    input  wire logic [CNT_W-1:0] min_in,
    output upd_result_t           result
);

    logic [CNT_W-1:0] count_new;

    always_comb begin
        if (inc && (count_in != COUNT_MAX)) begin
            count_new = count_in + CNT_W'(1);
        end else begin
            count_new = count_in;
        end
        result.count   = count_new;
        result.minimum = (count_new < min_in) ? count_new : min_in;
    end

endmodule

`default_nettype wire

>>> rtl/count_min_sketch_engine.sv
// Count-min sketch engine. Each request carries a 128-bit key hash and a command
// (increment or query); the block visits the active rows one after another in a
// single counter memory, each row with a read and then a saturating update and
// minimum, and puts the estimate in the output register; a special key or zero
// rows skip the row walk. A request is accepted only in idle, so the block takes
// no new request before the last one is through its steps. The next request is
// accepted while an estimate still waits on m_tready; a finished request then
// holds in its last step until the output register is free.
// After reset the block sweeps the whole table of MAX_ROWS * 2^MAX_WIDTH_LOG2
// counters (8192 with the defaults) to zero, one counter per cycle;
// s_tready stays low during the sweep, while configuration writes are taken.
`default_nettype none

`include "count_min_sketch_engine_assert.svh"

module count_min_sketch_engine
    import cmse_pkg::*;
#(
    parameter int MAX_ROWS       = DEF_MAX_ROWS,
    parameter int MAX_WIDTH_LOG2 = DEF_MAX_WIDTH_LOG2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic              cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [HASH_W-1:0] s_tdata,   // hash_low [63:0], hash_high [127:64]
    input  wire logic [1:0]        s_tuser,   // cmd [0], special_key [1]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CNT_W-1:0]       m_tdata    // estimate [31:0]
);

    localparam int DEPTH  = MAX_ROWS << MAX_WIDTH_LOG2;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WL_W   = $clog2(MAX_WIDTH_LOG2 + 1);
    localparam int RC_W   = $clog2(MAX_ROWS + 1);

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    cfg_wl_reg, cfg_rows_reg;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [RC_W-1:0]     row_reg, row_next;
    logic [RC_W-1:0]     r_item_reg, r_item_next;
    logic [WL_W-1:0]     w_item_reg, w_item_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic                inc_reg, inc_next;
    logic [CNT_W-1:0]    min_reg, min_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [WL_W-1:0]     w_clamp;
    logic [RC_W-1:0]     r_clamp;
    logic [MAX_WIDTH_LOG2-1:0] col;
    logic [ADDR_W-1:0]   row_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [CNT_W-1:0]    mem_wdata;
    logic [CNT_W-1:0]    mem_rdata;
    upd_result_t         upd;
    logic                s_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_wl_reg   <= RST_WIDTH_LOG2;
            cfg_rows_reg <= RST_ROWS;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WIDTH_LOG2: cfg_wl_reg   <= cfg_wdata;
                REG_ROWS:       cfg_rows_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        if (int'(cfg_wl_reg) > MAX_WIDTH_LOG2) begin
            w_clamp = WL_W'(MAX_WIDTH_LOG2);
        end else begin
            w_clamp = WL_W'(cfg_wl_reg);
        end
        if (int'(cfg_rows_reg) > MAX_ROWS) begin
            r_clamp = RC_W'(MAX_ROWS);
        end else begin
            r_clamp = RC_W'(cfg_rows_reg);
        end
    end

    assign col      = hash_reg[MAX_WIDTH_LOG2-1:0]
                      & ~({MAX_WIDTH_LOG2{1'b1}} << w_item_reg);
    assign row_addr = (ADDR_W'(row_reg) << w_item_reg) | ADDR_W'(col);
    assign s_accept = s_tvalid && s_tready;

    cmse_update_unit u_update (
        .inc      (inc_reg),
        .count_in (mem_rdata),
        .min_in   (min_reg),
        .result   (upd)
    );

    cmse_counter_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_item_reg  <= r_item_next;
        w_item_reg  <= w_item_next;
        hash_reg    <= hash_next;
        inc_reg     <= inc_next;
        min_reg     <= min_next;
        addr_reg    <= addr_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        row_next      = row_reg;
        r_item_next   = r_item_reg;
        w_item_next   = w_item_reg;
        hash_next     = hash_reg;
        inc_next      = inc_reg;
        min_next      = min_reg;
        addr_next     = addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = addr_reg;
        mem_wdata     = upd.count;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    hash_next   = s_tdata;
                    inc_next    = (s_tuser[0] == CMD_INC);
                    w_item_next = w_clamp;
                    r_item_next = r_clamp;
                    row_next    = '0;
                    min_next    = COUNT_MAX;
                    if (s_tuser[1]) begin
                        min_next   = SPECIAL_ESTIMATE;
                        state_next = ST_DONE;
                    end else if (r_clamp == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                mem_addr   = row_addr;
                addr_next  = row_addr;
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                mem_we    = inc_reg;
                min_next  = upd.minimum;
                hash_next = hash_reg >> w_item_reg;
                row_next  = row_reg + RC_W'(1);
                if (RC_W'(row_reg + RC_W'(1)) == r_item_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = min_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CMSE_ASSERT_NEXT(a_walk_starts, s_accept && !s_tuser[1] && (r_clamp != '0), state_reg == ST_READ)
    `CMSE_ASSERT_SAME(a_write_phase, mem_we, (state_reg == ST_MODIFY) || (state_reg == ST_CLEAR))
    `CMSE_ASSERT_SAME(a_result_source, $rose(m_tvalid_reg), $past(state_reg) == ST_DONE)
    `CMSE_ASSERT_SAME(a_row_in_range, state_reg == ST_READ, row_reg < r_item_reg)

endmodule

`default_nettype wire

>>> tb/tb.sv
module tb;
    import cmse_pkg::*;

    localparam int TABLE_DEPTH  = DEF_MAX_ROWS << DEF_MAX_WIDTH_LOG2;
    localparam int DRAIN_CYCLES = 4 * DEF_MAX_ROWS + 8;
    localparam int LONG_HOLD    = 200;
    localparam int KEY_POOL     = 8;

    typedef struct {
        logic        cmd;
        logic [63:0] hash_low;
        logic [63:0] hash_high;
        logic        special_key;
    } sketch_req_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_addr  = REG_WIDTH_LOG2;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [HASH_W-1:0] s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [CNT_W-1:0]  m_tdata;

    sketch_req_t      pending_reqs[$];
    logic [CNT_W-1:0] expected_estimates[$];
    logic [CNT_W-1:0] sketch_counts [TABLE_DEPTH];
    logic [127:0]     key_pool [KEY_POOL];
    logic [CFG_W-1:0] model_width_log2 = RST_WIDTH_LOG2;
    logic [CFG_W-1:0] model_rows       = RST_ROWS;
    sketch_req_t      offered_req;

    logic idle_on    = 1'b1;
    logic hold_start = 1'b0;
    int   hold_left  = 0;
    int   src_gap    = 0;
    int   sink_gap   = 0;
    int   failures   = 0;
    int   accepted_reqs   = 0;
    int   checked_results = 0;
    int   increments = 0;
    int   queries    = 0;
    int   specials   = 0;

    count_min_sketch_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic void report_failure(string what);
        failures++;
        if (failures <= 10) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endfunction

    function automatic logic [CNT_W-1:0] update_sketch(sketch_req_t req);
        logic [HASH_W-1:0] key_hash;
        logic [CNT_W-1:0]  lowest;
        int                w;
        int                r;
        int                col;
        int                idx;
        key_hash = {req.hash_high, req.hash_low};
        w = (model_width_log2 > DEF_MAX_WIDTH_LOG2) ? DEF_MAX_WIDTH_LOG2 : model_width_log2;
        r = (model_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : model_rows;
        lowest = COUNT_MAX;
        if (req.special_key) begin
            return SPECIAL_ESTIMATE;
        end
        for (int i = 0; i < r; i++) begin
            col = 0;
            for (int b = 0; b < w; b++) begin
                if (i * w + b < HASH_W && key_hash[i * w + b]) begin
                    col |= 1 << b;
                end
            end
            idx = (i << w) + col;
            if (idx >= TABLE_DEPTH) begin
                idx = TABLE_DEPTH - 1;
            end
            if (req.cmd == CMD_INC && sketch_counts[idx] != COUNT_MAX) begin
                sketch_counts[idx] += 1;
            end
            if (sketch_counts[idx] < lowest) begin
                lowest = sketch_counts[idx];
            end
        end
        return lowest;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_estimates.push_back(update_sketch(offered_req));
                accepted_reqs++;
                if (offered_req.special_key) begin
                    specials++;
                end else if (offered_req.cmd == CMD_INC) begin
                    increments++;
                end else begin
                    queries++;
                end
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                offered_req = pending_reqs.pop_front();
                s_tdata  <= {offered_req.hash_high, offered_req.hash_low};
                s_tuser  <= {offered_req.special_key, offered_req.cmd};
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) begin
                    src_gap <= $urandom_range(1, 5);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0) begin
                sink_gap <= $urandom_range(1, 5);
            end
        end
    end

    always @(posedge aclk) begin
        logic [CNT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_estimates.size() == 0) begin
                report_failure($sformatf("estimate %0d with no request outstanding", m_tdata));
            end else begin
                want = expected_estimates.pop_front();
                checked_results++;
                if (m_tdata !== want) begin
                    report_failure($sformatf("estimate %0d, expected %0d", m_tdata, want));
                end
            end
        end
    end

    task automatic push_req(logic cmd, logic [63:0] lo, logic [63:0] hi, logic special);
        sketch_req_t req;
        req.cmd         = cmd;
        req.hash_low    = lo;
        req.hash_high   = hi;
        req.special_key = special;
        pending_reqs.push_back(req);
    endtask

    // Most keys come from a small pool so that counters climb and collide.
    task automatic queue_random(int n);
        logic [127:0] key;
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) begin
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            end else begin
                key = {$urandom, $urandom, $urandom, $urandom};
            end
            push_req(($urandom_range(0, 2) == 0) ? CMD_QUERY : CMD_INC,
                     key[63:0], key[127:64], $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic write_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] r);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_WIDTH_LOG2;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr  <= REG_ROWS;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        model_width_log2 = w;
        model_rows       = r;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_estimates.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            sketch_counts[k] = '0;
        end
        for (int k = 0; k < KEY_POOL; k++) begin
            key_pool[k] = {$urandom, $urandom, $urandom, $urandom};
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_geometry(4'd10, 4'd4);
        push_req(CMD_INC,   '0, '0, 1'b0);
        push_req(CMD_INC,   '0, '0, 1'b0);
        push_req(CMD_QUERY, '0, '0, 1'b0);
        push_req(CMD_INC,   '1, '1, 1'b0);
        push_req(CMD_QUERY, '1, '1, 1'b0);
        push_req(CMD_INC,   '1, '1, 1'b1);
        push_req(CMD_QUERY, '0, '0, 1'b1);
        push_req(CMD_QUERY, '1, '1, 1'b0);
        push_req(CMD_INC,   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_req(CMD_INC,   64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
        push_req(CMD_QUERY, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_req(CMD_INC,   '0, '1, 1'b0);
        push_req(CMD_QUERY, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        queue_random(80);
        drain();

        write_geometry(4'd0, 4'd1);
        queue_random(70);
        drain();

        // The output side stalls for a long stretch while requests keep coming.
        write_geometry(4'd10, 4'd8);
        queue_random(100);
        @(posedge aclk);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        drain();

        write_geometry(4'd15, 4'd15);
        queue_random(60);
        drain();

        write_geometry(4'd3, 4'd0);
        queue_random(30);
        drain();

        write_geometry(4'd1, 4'd8);
        queue_random(80);
        drain();

        write_geometry(4'd12, 4'd9);
        queue_random(60);
        drain();

        write_geometry(4'd2, 4'd2);
        queue_random(60);
        drain();

        idle_on <= 1'b0;
        write_geometry(4'd4, 4'd5);
        queue_random(97);
        drain();

        $display("Checked %0d estimates for %0d requests: %0d increments, %0d queries, %0d special.",
                 checked_results, accepted_reqs, increments, queries, specials);
        $display("Geometries included zero width, zero rows, clamped width and rows, and a long stall.");
        if (failures == 0 && expected_estimates.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cmse_pkg.sv
rtl/cmse_counter_mem.sv
rtl/cmse_update_unit.sv
rtl/count_min_sketch_engine.sv
tb/tb.sv
